// File: rtl/qfit_pkg.sv
// Shared types and constants for the three-point quadratic fit.
package qfit_pkg;

    localparam int X_W     = 16;  // Q8.8 sample width
    localparam int COEF_W  = 48;  // Q24.24 coefficient width
    localparam int NUM_W   = 80;  // scaled numerator magnitude width
    localparam int DEN_W   = 51;  // determinant magnitude width
    localparam int STEPS   = COEF_W;          // quotient bits, one per divider stage
    localparam int HI_W    = NUM_W - STEPS;   // numerator bits above the quotient window

    localparam logic [COEF_W:0] LIM_POS = {2'b00, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W:0] LIM_NEG = {2'b01, {(COEF_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DEGEN = 2'd1,
        ST_SAT   = 2'd2
    } fit_status_t;

    typedef struct packed {
        logic signed [X_W-1:0] x_first;
        logic signed [X_W-1:0] y_first;
        logic signed [X_W-1:0] x_second;
        logic signed [X_W-1:0] y_second;
        logic signed [X_W-1:0] x_third;
        logic signed [X_W-1:0] y_third;
    } fit_in_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_square;
        logic signed [COEF_W-1:0] coef_linear;
        logic signed [COEF_W-1:0] coef_constant;
        fit_status_t              fit_status;
    } fit_out_t;

    typedef struct packed {
        logic neg;
        logic zero;
    } div_tag_t;

    typedef struct packed {
        logic [COEF_W-1:0] coef;
        logic              sat;
        logic              zero;
    } div_res_t;

endpackage

// File: rtl/qfit_div.sv
// Pipelined restoring divider with round-to-nearest and saturation to the coefficient range.
module qfit_div
    import qfit_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  div_tag_t         tag,
    output logic             out_valid,
    output div_res_t         res
);

    logic             v_reg   [0:STEPS];
    logic [DEN_W-1:0] rem_reg [0:STEPS];
    logic [DEN_W-1:0] d_reg   [0:STEPS];
    logic [STEPS-1:0] q_reg   [0:STEPS];
    logic [STEPS-1:0] lo_reg  [0:STEPS];
    logic             big_reg [0:STEPS];
    div_tag_t         tag_reg [0:STEPS];

    logic [HI_W-1:0]  hi;
    logic             big_next;

    // Numerator bits above the window decide overflow up front.
    always_comb
    begin
        hi       = num[NUM_W-1:STEPS];
        big_next = {{(DEN_W-HI_W){1'b0}}, hi} >= den;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= {{(DEN_W-HI_W){1'b0}}, hi};
        d_reg[0]   <= den;
        q_reg[0]   <= '0;
        lo_reg[0]  <= num[STEPS-1:0];
        big_reg[0] <= big_next;
        tag_reg[0] <= tag;
    end

    for (genvar k = 1; k <= STEPS; k++)
    begin : g_step
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] rem_next;

        always_comb
        begin
            trial    = {rem_reg[k-1], lo_reg[k-1][STEPS-1]};
            ge       = trial >= {1'b0, d_reg[k-1]};
            rem_next = ge ? DEN_W'(trial - {1'b0, d_reg[k-1]}) : trial[DEN_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            d_reg[k]   <= d_reg[k-1];
            q_reg[k]   <= {q_reg[k-1][STEPS-2:0], ge};
            lo_reg[k]  <= {lo_reg[k-1][STEPS-2:0], 1'b0};
            big_reg[k] <= big_reg[k-1];
            tag_reg[k] <= tag_reg[k-1];
        end
    end

    logic              rnd;
    logic [COEF_W:0]   qr;
    logic [COEF_W:0]   lim;
    logic              sat;
    logic [COEF_W-1:0] mag;
    div_res_t          res_next;
    div_res_t          res_reg;
    logic              out_valid_reg;

    // Round half away from zero on the magnitude, then clamp and restore sign.
    always_comb
    begin
        rnd  = {rem_reg[STEPS], 1'b0} >= {1'b0, d_reg[STEPS]};
        qr   = {1'b0, q_reg[STEPS]} + (COEF_W+1)'(rnd);
        lim  = tag_reg[STEPS].neg ? LIM_NEG : LIM_POS;
        sat  = big_reg[STEPS] || (qr > lim);
        mag  = sat ? lim[COEF_W-1:0] : qr[COEF_W-1:0];
        res_next.zero = tag_reg[STEPS].zero;
        if (tag_reg[STEPS].zero)
        begin
            res_next.coef = '0;
            res_next.sat  = 1'b0;
        end
        else
        begin
            res_next.coef = tag_reg[STEPS].neg ? (~mag + COEF_W'(1)) : mag;
            res_next.sat  = sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= v_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

// File: rtl/three_point_quadratic_fit.sv
// Top level of the three-point quadratic fit: numerator and determinant pipeline, three dividers.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+---------------------------------------
//  input    | start, busy          | item   (fit_in_t, three Q8.8 points)
//  result   | done (one-cycle)     | result (fit_out_t, Q24.24 a, b, c, status)
//
// One beat is taken every cycle; busy stays low since the pipeline never stops.
// Each result passes through six stages of products and sums, the divider input
// register, 48 divider stages (one quotient bit each), the rounding register and
// the output register.
// Reset clears only the valid bits; the receiver cannot stall, so nothing holds.
module three_point_quadratic_fit
    import qfit_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  fit_in_t  item,
    output logic     done,
    output fit_out_t result
);

    localparam int LAT = 6 + STEPS + 3;

    logic [6:1] v_reg;

    // stage 1: captured samples
    logic signed [15:0] x0_reg, x1_reg, x2_reg;
    logic signed [15:0] y0_1_reg, y1_1_reg, y2_1_reg;
    // stage 2: differences, squares, cross products
    logic signed [16:0] d01_reg, d02_reg, d12_reg;
    logic signed [31:0] sq0_reg, sq1_reg, sq2_reg;
    logic signed [31:0] p01_reg, p02_reg, p12_reg;
    logic signed [15:0] y0_2_reg, y1_2_reg, y2_2_reg;
    // stage 3
    logic signed [33:0] dd_reg;
    logic signed [16:0] d12_3_reg;
    logic signed [32:0] s12_reg, s20_reg, s01_reg;
    logic signed [48:0] c12_reg, c02_reg, c01_reg;
    logic signed [32:0] a0_reg, a1_reg, a2_reg;
    logic signed [15:0] y0_3_reg, y1_3_reg, y2_3_reg;
    // stage 4
    logic signed [50:0] den_reg;
    logic signed [34:0] na_reg;
    logic signed [48:0] b0_reg, b1_reg, b2_reg;
    logic signed [64:0] g0_reg, g1_reg, g2_reg;
    // stage 5
    logic signed [50:0] den_5_reg;
    logic signed [34:0] na_5_reg;
    logic signed [50:0] nb_reg;
    logic signed [66:0] nc_reg;
    // stage 6: magnitudes and scaled numerators
    logic [DEN_W-1:0] dmag_reg;
    logic [NUM_W-1:0] numa_reg, numb_reg, numc_reg;
    div_tag_t         taga_reg, tagb_reg, tagc_reg;

    logic [34:0] ma_next;
    logic [50:0] mb_next;
    logic [66:0] mc_next;
    logic [DEN_W-1:0] dmag_next;
    logic        zero_next;

    always_comb
    begin
        ma_next   = na_5_reg[34] ? $unsigned(-na_5_reg) : $unsigned(na_5_reg);
        mb_next   = nb_reg[50] ? $unsigned(-nb_reg) : $unsigned(nb_reg);
        mc_next   = nc_reg[66] ? $unsigned(-nc_reg) : $unsigned(nc_reg);
        dmag_next = den_5_reg[50] ? $unsigned(-den_5_reg) : $unsigned(den_5_reg);
        zero_next = (den_5_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[5:1], start & ~busy};
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg   <= item.x_first;
        x1_reg   <= item.x_second;
        x2_reg   <= item.x_third;
        y0_1_reg <= item.y_first;
        y1_1_reg <= item.y_second;
        y2_1_reg <= item.y_third;

        d01_reg  <= 17'(x0_reg) - 17'(x1_reg);
        d02_reg  <= 17'(x0_reg) - 17'(x2_reg);
        d12_reg  <= 17'(x1_reg) - 17'(x2_reg);
        sq0_reg  <= 32'(x0_reg) * 32'(x0_reg);
        sq1_reg  <= 32'(x1_reg) * 32'(x1_reg);
        sq2_reg  <= 32'(x2_reg) * 32'(x2_reg);
        p01_reg  <= 32'(x0_reg) * 32'(x1_reg);
        p02_reg  <= 32'(x0_reg) * 32'(x2_reg);
        p12_reg  <= 32'(x1_reg) * 32'(x2_reg);
        y0_2_reg <= y0_1_reg;
        y1_2_reg <= y1_1_reg;
        y2_2_reg <= y2_1_reg;

        dd_reg    <= 34'(d01_reg) * 34'(d02_reg);
        d12_3_reg <= d12_reg;
        s12_reg   <= 33'(sq1_reg) - 33'(sq2_reg);
        s20_reg   <= 33'(sq2_reg) - 33'(sq0_reg);
        s01_reg   <= 33'(sq0_reg) - 33'(sq1_reg);
        c12_reg   <= 49'(p12_reg) * 49'(d12_reg);
        c02_reg   <= 49'(p02_reg) * 49'(d02_reg);
        c01_reg   <= 49'(p01_reg) * 49'(d01_reg);
        a0_reg    <= 33'(y0_2_reg) * 33'(d12_reg);
        a1_reg    <= 33'(y1_2_reg) * 33'(d02_reg);
        a2_reg    <= 33'(y2_2_reg) * 33'(d01_reg);
        y0_3_reg  <= y0_2_reg;
        y1_3_reg  <= y1_2_reg;
        y2_3_reg  <= y2_2_reg;

        den_reg <= 51'(dd_reg) * 51'(d12_3_reg);
        na_reg  <= 35'(a0_reg) - 35'(a1_reg) + 35'(a2_reg);
        b0_reg  <= 49'(y0_3_reg) * 49'(s12_reg);
        b1_reg  <= 49'(y1_3_reg) * 49'(s20_reg);
        b2_reg  <= 49'(y2_3_reg) * 49'(s01_reg);
        g0_reg  <= 65'(y0_3_reg) * 65'(c12_reg);
        g1_reg  <= 65'(y1_3_reg) * 65'(c02_reg);
        g2_reg  <= 65'(y2_3_reg) * 65'(c01_reg);

        den_5_reg <= den_reg;
        na_5_reg  <= na_reg;
        nb_reg    <= 51'(0) - (51'(b0_reg) + 51'(b1_reg) + 51'(b2_reg));
        nc_reg    <= 67'(g0_reg) - 67'(g1_reg) + 67'(g2_reg);

        // scale by 2^32, 2^24 and 2^16 so each quotient lands in Q24.24
        dmag_reg <= dmag_next;
        numa_reg <= NUM_W'(ma_next) << 32;
        numb_reg <= NUM_W'(mb_next) << 24;
        numc_reg <= NUM_W'(mc_next) << 16;
        taga_reg <= '{neg: na_5_reg[34] ^ den_5_reg[50], zero: zero_next};
        tagb_reg <= '{neg: nb_reg[50] ^ den_5_reg[50], zero: zero_next};
        tagc_reg <= '{neg: nc_reg[66] ^ den_5_reg[50], zero: zero_next};
    end

    logic     va, vb, vc;
    div_res_t ra, rb, rc;

    qfit_div u_div_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_reg[6]),
        .num       (numa_reg),
        .den       (dmag_reg),
        .tag       (taga_reg),
        .out_valid (va),
        .res       (ra)
    );

    qfit_div u_div_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_reg[6]),
        .num       (numb_reg),
        .den       (dmag_reg),
        .tag       (tagb_reg),
        .out_valid (vb),
        .res       (rb)
    );

    qfit_div u_div_c (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_reg[6]),
        .num       (numc_reg),
        .den       (dmag_reg),
        .tag       (tagc_reg),
        .out_valid (vc),
        .res       (rc)
    );

    fit_out_t result_next;
    fit_out_t result_reg;
    logic     done_reg;

    always_comb
    begin
        result_next.coef_square   = ra.coef;
        result_next.coef_linear   = rb.coef;
        result_next.coef_constant = rc.coef;
        if (ra.zero)
        begin
            result_next.fit_status = ST_DEGEN;
        end
        else if (ra.sat || rb.sat || rc.sat)
        begin
            result_next.fit_status = ST_SAT;
        end
        else
        begin
            result_next.fit_status = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= va & vb & vc;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without matching start beat");

    a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        (va == vb) && (vb == vc))
        else $error("divider lanes out of step");

    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.fit_status == ST_DEGEN) |->
        (result.coef_square == '0 && result.coef_linear == '0
         && result.coef_constant == '0))
        else $error("degenerate fit with nonzero coefficient");

    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.fit_status == ST_SAT) |->
        (result.coef_square == LIM_POS[COEF_W-1:0] || result.coef_square == LIM_NEG[COEF_W-1:0]
         || result.coef_linear == LIM_POS[COEF_W-1:0]
         || result.coef_linear == LIM_NEG[COEF_W-1:0]
         || result.coef_constant == LIM_POS[COEF_W-1:0]
         || result.coef_constant == LIM_NEG[COEF_W-1:0]))
        else $error("saturation flagged but no coefficient at a limit");

endmodule

// File: test/three_point_quadratic_fit_tb.sv
// Testbench for the three-point quadratic fit: random and corner point triples checked against a predictor.
`timescale 1ns / 100ps

module three_point_quadratic_fit_tb
    import qfit_pkg::*;
();

    // Expected coefficients for each accepted triple, oldest first.
    class fit_scoreboard;
        fit_out_t pending_fits[$];
        int       mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Round (m * 2^k) / d to nearest, ties away; flag when over lim.
        function automatic logic [COEF_W-1:0] scaled_quotient(logic signed [63:0] num,
                                                             logic signed [63:0] den,
                                                             int k, ref logic sat);
            logic              neg;
            logic [127:0]      numer;
            logic [127:0]      mag_d;
            logic [127:0]      quo;
            logic [127:0]      rem;
            logic [127:0]      lim;
            neg   = (num < 0) != (den < 0);
            numer = (num < 0 ? 128'(-num) : 128'(num)) << k;
            mag_d = den < 0 ? 128'(-den) : 128'(den);
            quo   = numer / mag_d;
            rem   = numer % mag_d;
            if (rem >= mag_d - rem)
                quo = quo + 128'd1;
            lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
            if (quo > lim)
            begin
                quo = lim;
                sat = 1'b1;
            end
            return neg ? COEF_W'(-quo) : COEF_W'(quo);
        endfunction

        function automatic void note_triple(fit_in_t t);
            logic signed [63:0] x0, x1, x2, y0, y1, y2, d01, d02, d12, den, na, nb, nc;
            logic     sat;
            fit_out_t fit;
            x0 = 64'(t.x_first);  y0 = 64'(t.y_first);
            x1 = 64'(t.x_second); y1 = 64'(t.y_second);
            x2 = 64'(t.x_third);  y2 = 64'(t.y_third);
            d01 = x0 - x1; d02 = x0 - x2; d12 = x1 - x2;
            den = d01 * d02 * d12;
            sat = 1'b0;
            fit = '0;
            if (den == 0)
                fit.fit_status = ST_DEGEN;
            else
            begin
                na = y0 * d12 - y1 * d02 + y2 * d01;
                nb = -(y0 * (x1 * x1 - x2 * x2) + y1 * (x2 * x2 - x0 * x0)
                       + y2 * (x0 * x0 - x1 * x1));
                nc = y0 * ((x1 * x2) * d12) - y1 * ((x0 * x2) * d02)
                     + y2 * ((x0 * x1) * d01);
                fit.coef_square   = scaled_quotient(na, den, 32, sat);
                fit.coef_linear   = scaled_quotient(nb, den, 24, sat);
                fit.coef_constant = scaled_quotient(nc, den, 16, sat);
                fit.fit_status    = sat ? ST_SAT : ST_OK;
            end
            pending_fits.push_back(fit);
        endfunction

        task automatic report(string what);
            $display("mismatch at %0t: %s", $time, what);
            mismatches++;
        endtask

        task automatic check_fit(fit_out_t got);
            fit_out_t want;
            if (pending_fits.size() == 0)
            begin
                report("result with no triple pending");
                return;
            end
            want = pending_fits.pop_front();
            if (got.coef_square !== want.coef_square)
                report($sformatf("coef_square %h want %h", got.coef_square, want.coef_square));
            if (got.coef_linear !== want.coef_linear)
                report($sformatf("coef_linear %h want %h", got.coef_linear, want.coef_linear));
            if (got.coef_constant !== want.coef_constant)
                report($sformatf("coef_constant %h want %h",
                                 got.coef_constant, want.coef_constant));
            if (got.fit_status !== want.fit_status)
                report($sformatf("fit_status %0d want %0d", got.fit_status, want.fit_status));
        endtask
    endclass

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    fit_in_t       item;
    logic          done;
    fit_out_t      result;
    fit_scoreboard fits;
    bit            quiet_tail;

    three_point_quadratic_fit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Accepted beats go to the predictor, results to the check.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            fits.note_triple(item);
        if (rst_n && done)
            fits.check_fit(result);
    end

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // Hold the triple until a beat is taken, then maybe idle for a burst.
    task automatic send_triple(fit_in_t t);
        item  <= t;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        @(negedge clk);
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
    endtask

    task automatic send_points(int x0, int y0, int x1, int y1, int x2, int y2);
        fit_in_t t;
        t.x_first  = 16'(x0); t.y_first  = 16'(y0);
        t.x_second = 16'(x1); t.y_second = 16'(y1);
        t.x_third  = 16'(x2); t.y_third  = 16'(y2);
        send_triple(t);
    endtask

    initial
    begin
        fit_in_t t;
        int      n;
        int      x0;
        fits       = new();
        quiet_tail = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        item       = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: simple parabola, line, coincident abscissae, extremes, saturation.
        send_points(-256, 256, 0, 0, 256, 256);
        send_points(0, 0, 256, 512, 512, 1024);
        send_points(100, 5, 100, 7, 300, 9);
        send_points(7, 1, 9, 2, 9, 3);
        send_points(5, 5, 5, 5, 5, 5);
        send_points(-32768, -32768, 0, 32767, 32767, -32768);
        send_points(-32768, 32767, 32767, 32767, 0, -32768);
        send_points(0, 32767, 1, -32768, 2, 32767);
        send_points(0, -32768, 1, 32767, 2, -32768);
        send_points(-32768, 32767, -32767, -32768, -32766, 32767);
        send_points(32765, 32767, 32766, -32768, 32767, 32767);
        send_points(1, 1, 2, 1, 3, 2);
        send_points(0, 1, 2, 0, 4, 0);
        send_points(-1, -1, 0, 0, 1, -1);
        send_points(0, 0, 0, 0, 0, 0);
        send_points(32767, 0, -32768, 0, 0, 0);

        for (n = 0; n < 450; n++)
        begin
            quiet_tail = n >= 380;
            t.y_first  = 16'($urandom);
            t.y_second = 16'($urandom);
            t.y_third  = 16'($urandom);
            if ($urandom_range(0, 9) == 0)
            begin
                // At least two abscissae shared.
                x0 = int'(rand_coord());
                t.x_first  = 16'(x0);
                t.x_second = $urandom_range(0, 1) ? 16'(x0) : rand_coord();
                t.x_third  = $urandom_range(0, 1) ? 16'(x0) : t.x_second;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                // Close spacing drives coefficients toward saturation.
                x0 = $urandom_range(0, 65000) - 32768;
                t.x_first  = 16'(x0);
                t.x_second = 16'(x0 + $urandom_range(1, 3));
                t.x_third  = 16'(x0 + $urandom_range(4, 7));
            end
            else
            begin
                t.x_first  = rand_coord();
                t.x_second = rand_coord();
                t.x_third  = rand_coord();
            end
            send_triple(t);
        end
        start <= 1'b0;

        n = 0;
        while (fits.pending_fits.size() != 0 && n < 2000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (80) @(posedge clk);
        if (fits.pending_fits.size() != 0)
            fits.report("fits still pending at end");
        if (fits.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
